// File: rtl/core/cdc_pkg.sv
// Package with the shared types, constants and month length function of the date counter.
`default_nettype none
package cdc_pkg;

   localparam int unsigned MONTH_W     = 4;
   localparam int unsigned DAY_W       = 5;
   localparam int unsigned YEAR_W      = 12;
   localparam int unsigned COUNT_W     = 10;
   localparam int unsigned CENT_Q_W    = 6;
   localparam int unsigned CENT_R_W    = 7;

   localparam int unsigned COUNT_MAX_DEFAULT = 1023;

   localparam logic [YEAR_W-1:0]  YEAR_MIN_EXCL = 12'd1800;
   localparam logic [YEAR_W-1:0]  YEAR_MAX      = 12'd2500;
   localparam logic [YEAR_W-1:0]  YEAR_DEFAULT  = 12'd1990;
   localparam logic [YEAR_W-1:0]  YEAR_LIMIT    = 12'd4095;
   localparam logic [CENT_R_W-1:0] REM_DEFAULT  = 7'd90;
   localparam logic [1:0]         CENT_Q4_DEFAULT = 2'd3;
   localparam logic [CENT_R_W-1:0] REM_LAST     = 7'd99;
   localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST     = 5'd1;

   // Reciprocal of 100 scaled by 2**19, exact for every 12-bit year.
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int unsigned RECIP_SHIFT = 19;

   localparam logic OP_SET     = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_FIX  = 5'b00010,
      ST_VDAY = 5'b00100,
      ST_STEP = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic fix;
      logic inc;
   } year_ctl_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/cdc_if.sv
// Valid/ready channel interfaces for the request and the response of the date counter.
`default_nettype none
interface cdc_req_if
   import cdc_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [MONTH_W-1:0] new_month;
   logic [DAY_W-1:0]   new_day;
   logic [YEAR_W-1:0]  new_year;
   logic [COUNT_W-1:0] day_count;

   modport source (output valid, operation, new_month, new_day, new_year, day_count,
                   input ready);
   modport sink   (input valid, operation, new_month, new_day, new_year, day_count,
                   output ready);
endinterface

interface cdc_rsp_if
   import cdc_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [MONTH_W-1:0] cur_month;
   logic [DAY_W-1:0]   cur_day;
   logic [YEAR_W-1:0]  cur_year;

   modport source (output valid, cur_month, cur_day, cur_year, input ready);
   modport sink   (input valid, cur_month, cur_day, cur_year, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cdc_year_track.sv
// Year register with incremental century remainder tracking and the leap year flag.
`default_nettype none
module cdc_year_track
   import cdc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire year_ctl_type      ctl,
   input  wire logic [YEAR_W-1:0] load_year,
   output logic [YEAR_W-1:0]      year,
   output logic                   leap
);

   logic [YEAR_W-1:0]   year_ff,  year_in;
   logic [CENT_R_W-1:0] rem_ff,   rem_in;
   logic [1:0]          q4_ff,    q4_in;
   logic [CENT_Q_W-1:0] quot_ff,  quot_in;
   logic [24:0]         prod;
   logic [YEAR_W-1:0]   hundreds;
   logic [YEAR_W-1:0]   diff;

   assign prod     = load_year * RECIP_100;
   assign quot_in  = prod[RECIP_SHIFT +: CENT_Q_W];
   assign hundreds = ({6'd0, quot_ff} << 6) + ({6'd0, quot_ff} << 5) + ({6'd0, quot_ff} << 2);
   assign diff     = year_ff - hundreds;

   always_comb begin
      year_in = year_ff;
      rem_in  = rem_ff;
      q4_in   = q4_ff;
      if (ctl.load) begin
         year_in = load_year;
      end else if (ctl.fix) begin
         rem_in = diff[CENT_R_W-1:0];
         q4_in  = quot_ff[1:0];
      end else if (ctl.inc) begin
         year_in = year_ff + 12'd1;
         if (rem_ff == REM_LAST) begin
            rem_in = '0;
            q4_in  = q4_ff + 2'd1;
         end else begin
            rem_in = rem_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff <= YEAR_DEFAULT;
         rem_ff  <= REM_DEFAULT;
         q4_ff   <= CENT_Q4_DEFAULT;
      end else begin
         year_ff <= year_in;
         rem_ff  <= rem_in;
         q4_ff   <= q4_in;
      end
      quot_ff <= quot_in;
   end

   assign year = year_ff;
   assign leap = (year_ff[1:0] == 2'd0) && ((rem_ff != '0) || (q4_ff == 2'd0));

endmodule
`default_nettype wire

// File: rtl/core/calendar_date_counter_unit.sv
// Top level of the date counter: sequencer, month and day registers and the day step unit.
// A set request passes through ST_FIX and ST_VDAY before the response is valid in ST_RESP.
// An advance request works through the clamped day count in ST_STEP, one day stepped per cycle, then responds.
// Only one request is in flight; the next is accepted in the cycle after the response is taken.
// Synchronous active-high reset puts the date at January 1, 1990 and the sequencer idle.
`default_nettype none
module calendar_date_counter_unit
   import cdc_pkg::*;
#(
   parameter int unsigned COUNT_MAX = COUNT_MAX_DEFAULT
)(
   input  wire logic  clock,
   input  wire logic  reset,
   cdc_req_if.sink    req_chan,
   cdc_rsp_if.source  rsp_chan
);

   state_type           state_ff, state_in;
   logic [MONTH_W-1:0]  month_ff, month_in;
   logic [DAY_W-1:0]    day_ff,   day_in;
   logic [DAY_W-1:0]    pend_day_ff, pend_day_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [YEAR_W-1:0]   year;
   logic [YEAR_W-1:0]   valid_year;
   logic [MONTH_W-1:0]  valid_month;
   logic [DAY_W-1:0]    cur_len;
   logic                leap;
   logic                accept;
   year_ctl_type        year_ctl;

   cdc_year_track u_year (
      .clock     (clock),
      .reset     (reset),
      .ctl       (year_ctl),
      .load_year (valid_year),
      .year      (year),
      .leap      (leap)
   );

   assign accept      = req_chan.valid && req_chan.ready;
   assign valid_month = (req_chan.new_month >= MONTH_FIRST && req_chan.new_month <= MONTH_LAST)
                        ? req_chan.new_month : MONTH_FIRST;
   assign valid_year  = (req_chan.new_year > YEAR_MIN_EXCL && req_chan.new_year <= YEAR_MAX)
                        ? req_chan.new_year : YEAR_DEFAULT;
   assign cur_len     = month_len(month_ff, leap);

   always_comb begin
      state_in    = state_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      pend_day_in = pend_day_ff;
      count_in    = count_ff;
      year_ctl    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.operation == OP_SET) begin
                  month_in      = valid_month;
                  pend_day_in   = req_chan.new_day;
                  year_ctl.load = 1'b1;
                  state_in      = ST_FIX;
               end else begin
                  count_in = (32'(req_chan.day_count) > COUNT_MAX)
                             ? COUNT_W'(COUNT_MAX) : req_chan.day_count;
                  state_in = ST_STEP;
               end
            end
         end
         ST_FIX: begin
            year_ctl.fix = 1'b1;
            state_in     = ST_VDAY;
         end
         ST_VDAY: begin
            day_in   = (pend_day_ff >= DAY_FIRST && pend_day_ff <= cur_len)
                       ? pend_day_ff : DAY_FIRST;
            state_in = ST_RESP;
         end
         ST_STEP: begin
            if (count_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               count_in = count_ff - 10'd1;
               if (day_ff < cur_len) begin
                  day_in = day_ff + 5'd1;
               end else if (month_ff < MONTH_LAST) begin
                  month_in = month_ff + 4'd1;
                  day_in   = DAY_FIRST;
               end else if (year < YEAR_LIMIT) begin
                  year_ctl.inc = 1'b1;
                  month_in     = MONTH_FIRST;
                  day_in       = DAY_FIRST;
               end
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         month_ff <= MONTH_FIRST;
         day_ff   <= DAY_FIRST;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         count_ff <= count_in;
      end
      pend_day_ff <= pend_day_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = (state_ff == ST_RESP);
   assign rsp_chan.cur_month = month_ff;
   assign rsp_chan.cur_day   = day_ff;
   assign rsp_chan.cur_year  = year;

endmodule
`default_nettype wire
